### src/sedc_pkg.sv
// Shared types and constants for the sector EDC engine.
package sedc_pkg;

  localparam int unsigned POS_W = 12;
  localparam logic [POS_W-1:0] POS_MAX = '1;
  localparam logic [POS_W-1:0] EDC_SPAN = 12'd2064;
  localparam logic [31:0] EDC_POLY = 32'hD801_8001;
  localparam int unsigned TRAILER_LEN = 12;
  localparam int unsigned BEAT_W = $clog2(TRAILER_LEN);
  localparam int unsigned QDEPTH = 2;
  localparam int unsigned QPTR_W = $clog2(QDEPTH);
  localparam int unsigned QCNT_W = $clog2(QDEPTH + 1);
  localparam int unsigned CFG_AW = 3;
  localparam logic REG_EDC_MODE = 1'b0;

  typedef enum logic {
    JOB_GEN = 1'b0,
    JOB_VER = 1'b1
  } job_kind_t;

  typedef struct packed {
    job_kind_t   kind;
    logic [31:0] crc;
    logic        match;
  } job_t;

endpackage

### src/sedc_if.sv
// Valid/ready channel interfaces for sector bytes and result items.
interface sedc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       sector_start;

  modport source (output valid, output data_byte, output sector_start, input ready);
  modport sink (input valid, input data_byte, input sector_start, output ready);
endinterface

interface sedc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  out_byte;
  logic        trailer_last;
  logic [31:0] edc_value;
  logic        edc_match;

  modport source (output valid, output out_byte, output trailer_last,
                  output edc_value, output edc_match, input ready);
  modport sink (input valid, input out_byte, input trailer_last,
                input edc_value, input edc_match, output ready);
endinterface

### src/sedc_front.sv
// Front end: byte intake, CRC-32 update, position tracking and job issue.
module sedc_front (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           edc_mode,
  sedc_in_if.sink        in_ch,
  input  logic           q_full,
  output logic           push,
  output sedc_pkg::job_t push_job
);

  logic [31:0]                crc_r, crc_nxt;
  logic [sedc_pkg::POS_W-1:0] pos_r, pos_nxt;
  logic [31:0]                stored_r, stored_nxt;
  logic [31:0]                crc_cur;
  logic [sedc_pkg::POS_W-1:0] pos_cur;
  logic [sedc_pkg::POS_W-1:0] lane_full;
  logic [1:0]                 lane;
  logic                       accept;

  function automatic logic [31:0] crc_byte(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ sedc_pkg::EDC_POLY) : (v >> 1);
    end
    return v ^ (crc >> 8);
  endfunction

  assign in_ch.ready = !q_full;
  assign accept = in_ch.valid && in_ch.ready;
  assign crc_cur = in_ch.sector_start ? 32'd0 : crc_r;
  assign pos_cur = in_ch.sector_start ? '0 : pos_r;
  assign lane_full = pos_cur - sedc_pkg::EDC_SPAN;
  assign lane = lane_full[1:0];

  always_comb begin
    crc_nxt = crc_cur;
    stored_nxt = stored_r;
    push = 1'b0;
    push_job.kind = sedc_pkg::JOB_GEN;
    push_job.crc = crc_cur;
    push_job.match = 1'b0;
    pos_nxt = (pos_cur < sedc_pkg::POS_MAX) ? pos_cur + 1'b1 : pos_cur;
    if (pos_cur < sedc_pkg::EDC_SPAN) begin
      crc_nxt = crc_byte(crc_cur, in_ch.data_byte);
    end else if (pos_cur < sedc_pkg::EDC_SPAN + 12'd4) begin
      if (!edc_mode) begin
        push = accept && (lane == 2'd0);
      end else begin
        case (lane)
          2'd0: stored_nxt[7:0] = in_ch.data_byte;
          2'd1: stored_nxt[15:8] = in_ch.data_byte;
          2'd2: stored_nxt[23:16] = in_ch.data_byte;
          default: stored_nxt[31:24] = in_ch.data_byte;
        endcase
        push = accept && (lane == 2'd3);
        push_job.kind = sedc_pkg::JOB_VER;
        push_job.match = (stored_nxt == crc_cur);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      crc_r <= '0;
      pos_r <= '0;
      stored_r <= '0;
    end else if (accept) begin
      crc_r <= crc_nxt;
      pos_r <= pos_nxt;
      stored_r <= stored_nxt;
    end
  end

endmodule

### src/sedc_fifo.sv
// Short job queue between the front end and the result sequencer.
module sedc_fifo (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  sedc_pkg::job_t push_job,
  output logic           full,
  input  logic           pop,
  output logic           head_valid,
  output sedc_pkg::job_t head_job
);

  sedc_pkg::job_t              mem_r [sedc_pkg::QDEPTH];
  logic [sedc_pkg::QPTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [sedc_pkg::QCNT_W-1:0] count_r, count_nxt;
  logic                        do_pop;

  assign full = (count_r == sedc_pkg::QCNT_W'(sedc_pkg::QDEPTH));
  assign head_valid = (count_r != '0);
  assign head_job = mem_r[rd_ptr_r];
  assign do_pop = pop && head_valid;

  always_comb begin
    count_nxt = count_r;
    if (push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_job;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_nxt;
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n) !(push && full))
    else $error("job pushed into full queue");
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= sedc_pkg::QCNT_W'(sedc_pkg::QDEPTH))
    else $error("queue count beyond depth");
  a_push_seen: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !pop) |=> head_valid)
    else $error("pushed job not visible at queue head");

endmodule

### src/sedc_back.sv
// Result sequencer: expands queued jobs into registered result items.
module sedc_back (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           head_valid,
  input  sedc_pkg::job_t head_job,
  output logic           pop,
  sedc_out_if.source     out_ch
);

  logic [sedc_pkg::BEAT_W-1:0] beat_r;
  logic                        valid_r;
  logic [7:0]                  byte_r, byte_nxt;
  logic                        last_r, last_nxt;
  logic [31:0]                 edc_r;
  logic                        match_r;
  logic                        load;

  assign load = head_valid && (!valid_r || out_ch.ready);
  assign pop = load && last_nxt;

  always_comb begin
    byte_nxt = 8'd0;
    last_nxt = 1'b1;
    if (head_job.kind == sedc_pkg::JOB_GEN) begin
      last_nxt = (beat_r == sedc_pkg::BEAT_W'(sedc_pkg::TRAILER_LEN - 1));
      case (beat_r)
        sedc_pkg::BEAT_W'(0): byte_nxt = head_job.crc[7:0];
        sedc_pkg::BEAT_W'(1): byte_nxt = head_job.crc[15:8];
        sedc_pkg::BEAT_W'(2): byte_nxt = head_job.crc[23:16];
        sedc_pkg::BEAT_W'(3): byte_nxt = head_job.crc[31:24];
        default: byte_nxt = 8'd0;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      byte_r <= byte_nxt;
      last_r <= last_nxt;
      edc_r <= head_job.crc;
      match_r <= head_job.match;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
      beat_r <= '0;
    end else begin
      if (load) begin
        valid_r <= 1'b1;
        beat_r <= last_nxt ? '0 : beat_r + 1'b1;
      end else if (out_ch.ready) begin
        valid_r <= 1'b0;
      end
    end
  end

  assign out_ch.valid = valid_r;
  assign out_ch.out_byte = byte_r;
  assign out_ch.trailer_last = last_r;
  assign out_ch.edc_value = edc_r;
  assign out_ch.edc_match = match_r;

endmodule

### src/sector_edc_crc32_engine_unit.sv
// Top level: CD-ROM Mode 1 EDC engine with APB mode register.
// Accepts one sector byte per cycle; input stalls only while the job queue is full.
// Generate mode: twelve trailer items after byte 2064, one per cycle unless the sink stalls.
// Verify mode: one item after the last stored EDC byte, via the job queue and output register.
// Results: one item per cycle unless the sink stalls, set by the sequencer output register.
// Synchronous active-low reset clears CRC, position, stored EDC, queue and mode.
module sector_edc_crc32_engine_unit (
  input  logic                        clk,
  input  logic                        rst_n,
  sedc_in_if.sink                     in_chan,
  sedc_out_if.source                  out_chan,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sedc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  output logic [31:0]                 cfg_prdata,
  output logic                        cfg_pready
);

  logic           edc_mode_r;
  logic           q_full;
  logic           push;
  sedc_pkg::job_t push_job;
  logic           pop;
  logic           head_valid;
  sedc_pkg::job_t head_job;
  logic           cfg_hit;

  assign cfg_pready = 1'b1;
  assign cfg_hit = (cfg_paddr[sedc_pkg::CFG_AW-1] == sedc_pkg::REG_EDC_MODE);
  assign cfg_prdata = cfg_hit ? {31'd0, edc_mode_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      edc_mode_r <= 1'b0;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_hit) begin
      edc_mode_r <= cfg_pwdata[0];
    end
  end

  sedc_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .edc_mode (edc_mode_r),
    .in_ch    (in_chan),
    .q_full   (q_full),
    .push     (push),
    .push_job (push_job)
  );

  sedc_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_job   (push_job),
    .full       (q_full),
    .pop        (pop),
    .head_valid (head_valid),
    .head_job   (head_job)
  );

  sedc_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .head_valid (head_valid),
    .head_job   (head_job),
    .pop        (pop),
    .out_ch     (out_chan)
  );

endmodule

### verif/sedc_tb_pkg.sv
// Shared verification helpers for the sector EDC engine: register address and CRC byte step.
package sedc_tb_pkg;

  import sedc_pkg::*;

  localparam logic [CFG_AW-1:0] EDC_MODE_ADDR = {REG_EDC_MODE, 2'b00};

  function automatic logic [31:0] edc_fold(input logic [31:0] crc, input logic [7:0] b);
    logic [31:0] v;
    v = {24'd0, crc[7:0] ^ b};
    for (int k = 0; k < 8; k++) begin
      v = v[0] ? ((v >> 1) ^ EDC_POLY) : (v >> 1);
    end
    return v ^ (crc >> 8);
  endfunction

endpackage

### verif/sector_edc_checker.sv
// Checker for the sector EDC engine: tracks mode writes, predicts trailer items, compares output.
module sector_edc_checker (
  input  logic                        clk,
  input  logic                        rst_n,
  sedc_in_if                          in_mon,
  sedc_out_if                         out_mon,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [sedc_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [31:0]                 cfg_pwdata,
  input  logic                        cfg_pready,
  output int unsigned                 mismatches,
  output int unsigned                 outstanding
);
  timeunit 1ns;
  timeprecision 1ps;

  import sedc_pkg::*;
  import sedc_tb_pkg::*;

  typedef struct packed {
    logic [7:0]  out_byte;
    logic        trailer_last;
    logic [31:0] edc_value;
    logic        edc_match;
  } trailer_item_t;

  trailer_item_t    awaited_q[$];
  logic [31:0]      crc_acc;
  logic [POS_W-1:0] sector_pos;
  logic [31:0]      edc_capture;
  job_kind_t        mode_now;
  int unsigned      fail_tally = 0;

  task automatic take_byte(input logic [7:0] b, input logic st);
    logic [POS_W-1:0] p;
    logic [POS_W-1:0] offs;
    logic [1:0]       lane;
    trailer_item_t    it;
    if (st) begin
      crc_acc    = '0;
      sector_pos = '0;
    end
    p    = sector_pos;
    offs = p - EDC_SPAN;
    lane = offs[1:0];
    if (p < EDC_SPAN) begin
      crc_acc = edc_fold(crc_acc, b);
    end else if (p < EDC_SPAN + 12'd4) begin
      if (mode_now == JOB_GEN) begin
        if (lane == 2'd0) begin
          for (int k = 0; k < TRAILER_LEN; k++) begin
            it.out_byte     = (k < 4) ? crc_acc[8*k +: 8] : 8'h00;
            it.trailer_last = (k == TRAILER_LEN - 1);
            it.edc_value    = crc_acc;
            it.edc_match    = 1'b0;
            awaited_q.push_back(it);
          end
        end
      end else begin
        edc_capture[8*lane +: 8] = b;
        if (lane == 2'd3) begin
          it.out_byte     = 8'h00;
          it.trailer_last = 1'b1;
          it.edc_value    = crc_acc;
          it.edc_match    = (edc_capture == crc_acc);
          awaited_q.push_back(it);
        end
      end
    end
    if (sector_pos != POS_MAX) sector_pos = sector_pos + 1'b1;
  endtask

  task automatic check_item();
    trailer_item_t want;
    if (awaited_q.size() == 0) begin
      $error("unexpected item: out_byte %h trailer_last %b edc_value %h edc_match %b",
             out_mon.out_byte, out_mon.trailer_last, out_mon.edc_value, out_mon.edc_match);
      fail_tally++;
    end else begin
      want = awaited_q.pop_front();
      if (out_mon.out_byte !== want.out_byte) begin
        $error("out_byte: expected %h, got %h", want.out_byte, out_mon.out_byte);
        fail_tally++;
      end
      if (out_mon.trailer_last !== want.trailer_last) begin
        $error("trailer_last: expected %b, got %b", want.trailer_last, out_mon.trailer_last);
        fail_tally++;
      end
      if (out_mon.edc_value !== want.edc_value) begin
        $error("edc_value: expected %h, got %h", want.edc_value, out_mon.edc_value);
        fail_tally++;
      end
      if (out_mon.edc_match !== want.edc_match) begin
        $error("edc_match: expected %b, got %b", want.edc_match, out_mon.edc_match);
        fail_tally++;
      end
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      awaited_q.delete();
      crc_acc     = '0;
      sector_pos  = '0;
      edc_capture = '0;
      mode_now    = JOB_GEN;
    end else begin
      if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready && cfg_paddr == EDC_MODE_ADDR) begin
        mode_now = job_kind_t'(cfg_pwdata[0]);
      end
      if (out_mon.valid && out_mon.ready) check_item();
      if (in_mon.valid && in_mon.ready) take_byte(in_mon.data_byte, in_mon.sector_start);
    end
    mismatches  <= fail_tally;
    outstanding <= awaited_q.size();
  end

endmodule

### verif/sector_edc_crc32_engine_unit_tb.sv
// Testbench top for the sector EDC engine: clock, reset, sector stimulus, mode writes, verdict.
module sector_edc_crc32_engine_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import sedc_pkg::*;
  import sedc_tb_pkg::*;

  typedef enum {SINK_RANDOM, SINK_STEADY, SINK_HOLD} sink_plan_t;
  typedef enum {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_t;

  localparam int          HOLD_CYCLES   = 12000;
  localparam int          SETTLE_CYCLES = 8;
  localparam int          EXTRA_MAX     = 12;
  localparam int          EPISODES      = 16;
  localparam int unsigned RUN_LIMIT_NS  = 100_000_000;

  logic              clk;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [31:0]       cfg_pwdata;
  logic [31:0]       cfg_prdata;
  logic              cfg_pready;
  int unsigned       mismatches;
  int unsigned       outstanding;
  bit                src_gaps;
  sink_plan_t        sink_plan;

  sedc_in_if  in_chan ();
  sedc_out_if out_chan ();

  sector_edc_crc32_engine_unit dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_chan     (in_chan),
    .out_chan    (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  sector_edc_checker chk (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_mon      (in_chan),
    .out_mon     (out_chan),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_pready  (cfg_pready),
    .mismatches  (mismatches),
    .outstanding (outstanding)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("** sector_edc_crc32_engine_unit: FAILED **");
    $finish;
  end

  initial begin
    out_chan.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (sink_plan == SINK_HOLD) begin
        out_chan.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
        sink_plan = SINK_RANDOM;
      end else if (sink_plan == SINK_STEADY) begin
        out_chan.ready <= 1'b1;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= 30);
      end
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic st);
    if (src_gaps && $urandom_range(99) < 30) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < 30) @(posedge clk);
    end
    in_chan.valid        <= 1'b1;
    in_chan.data_byte    <= b;
    in_chan.sector_start <= st;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
  endtask

  task automatic send_stream(input int count, input logic first_start, input bit noisy);
    for (int i = 0; i < count; i++) begin
      send_byte(8'($urandom_range(255)),
                (i == 0) ? first_start : (noisy && $urandom_range(299) == 0));
    end
  endtask

  task automatic send_sector(input fill_t fill, input bit good_edc, input int extra);
    logic [31:0] sector_edc;
    logic [31:0] stored;
    logic [7:0]  b;
    sector_edc = '0;
    for (int i = 0; i < int'(EDC_SPAN); i++) begin
      case (fill)
        FILL_ZERO: b = 8'h00;
        FILL_ONES: b = 8'hFF;
        default:   b = 8'($urandom_range(255));
      endcase
      send_byte(b, i == 0);
      sector_edc = edc_fold(sector_edc, b);
    end
    stored = good_edc ? sector_edc : sector_edc ^ (32'h1 << $urandom_range(31));
    for (int k = 0; k < 4; k++) send_byte(stored[8*k +: 8], 1'b0);
    send_stream(extra, 1'b0, 1'b0);
  endtask

  task automatic drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic set_mode(input job_kind_t m);
    drain();
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= EDC_MODE_ADDR;
    cfg_pwdata  <= 32'(m);
    @(posedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
  endtask

  initial begin
    rst_n                <= 1'b0;
    in_chan.valid        <= 1'b0;
    in_chan.data_byte    <= 8'h00;
    in_chan.sector_start <= 1'b0;
    cfg_psel             <= 1'b0;
    cfg_penable          <= 1'b0;
    cfg_pwrite           <= 1'b0;
    cfg_paddr            <= '0;
    cfg_pwdata           <= '0;
    src_gaps  = 1'b1;
    sink_plan = SINK_RANDOM;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    send_sector(FILL_ZERO, 1'b1, 0);
    send_sector(FILL_ONES, 1'b1, 2);
    set_mode(JOB_VER);
    send_sector(FILL_ZERO, 1'b1, 0);
    send_sector(FILL_ONES, 1'b0, 0);
    send_sector(FILL_RANDOM, 1'b1, 3);

    // continue a sector without a start flag
    send_stream(1000, 1'b1, 1'b0);
    send_stream(int'(EDC_SPAN) + 4 - 1000, 1'b0, 1'b0);

    // switch mode inside the stored EDC bytes
    send_stream(int'(EDC_SPAN) + 2, 1'b1, 1'b0);
    set_mode(JOB_GEN);
    send_stream(2, 1'b0, 1'b0);
    send_stream(int'(EDC_SPAN) + 1, 1'b1, 1'b0);
    set_mode(JOB_VER);
    send_stream(3, 1'b0, 1'b0);

    // run past the position limit with no restart
    set_mode(JOB_GEN);
    send_stream(6300, 1'b1, 1'b0);

    send_stream(700, 1'b1, 1'b0);
    send_sector(FILL_RANDOM, 1'b1, 0);

    // stall the result side while sectors keep coming
    src_gaps  = 1'b0;
    sink_plan = SINK_HOLD;
    repeat (5) send_sector(FILL_RANDOM, 1'b1, 0);
    src_gaps = 1'b1;
    drain();

    for (int ep = 0; ep < EPISODES; ep++) begin
      if (ep == 0) begin
        src_gaps  = 1'b0;
        sink_plan = SINK_STEADY;
      end
      if (ep == 3) begin
        src_gaps  = 1'b1;
        sink_plan = SINK_RANDOM;
      end
      if ($urandom_range(3) == 0) set_mode(job_kind_t'($urandom_range(1)));
      if ($urandom_range(9) < 7) begin
        send_sector(FILL_RANDOM, $urandom_range(1), $urandom_range(EXTRA_MAX));
      end else begin
        send_stream($urandom_range(1, 3000), $urandom_range(1), 1'b1);
      end
    end

    drain();
    if (mismatches == 0) begin
      $display("** sector_edc_crc32_engine_unit: PASSED **");
    end else begin
      $display("** sector_edc_crc32_engine_unit: FAILED **");
    end
    $finish;
  end

endmodule
